// File: hw/rtl/utf8_to_unicode_escape_core_assert.svh
// assertion macros for the utf-8 to unicode escape core
`ifndef UTF8_TO_UNICODE_ESCAPE_CORE_ASSERT_SVH
`define UTF8_TO_UNICODE_ESCAPE_CORE_ASSERT_SVH

// check a property on every rising clock edge outside reset
`define U2UE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition implies another one in the next cycle
`define U2UE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/u2ue_pkg.sv
// shared types, constants and helper functions for the utf-8 to unicode escape core
package u2ue_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int ESC_LEN         = 6;

  localparam logic [15:0] UNIT_LOW_LIMIT  = 16'h0020;
  localparam logic [15:0] UNIT_HIGH_LIMIT = 16'h007E;
  localparam logic [15:0] HIGH_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
  localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;

  // one utf-16 unit on its way from front to back
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        done;
  } unit_beat_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DECODE,
    FS_LOW
  } front_state_t;

  // followers a lead byte calls for, zero for any other byte
  function automatic logic [1:0] followers_of(input logic [7:0] c);
    logic [1:0] f;
    f = 2'd0;
    if (c[7:5] == 3'b110) f = 2'd1;
    else if (c[7:4] == 4'hE) f = 2'd2;
    else if (c[7:3] == 5'h1E) f = 2'd3;
    return f;
  endfunction

  function automatic logic needs_escape(input logic [15:0] u);
    return (u < UNIT_LOW_LIMIT) || (u > UNIT_HIGH_LIMIT);
  endfunction

  // lower-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) ch = CHAR_DIGIT_0 + {4'b0, n};
    else ch = CHAR_LOWER_A + {4'b0, n - 4'd10};
    return ch;
  endfunction

endpackage

// File: hw/rtl/u2ue_front.sv
// front end: gathers utf-8 sequences and decodes runs into utf-16 units
module u2ue_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_end_of_text,
  output logic                  q_push,
  output u2ue_pkg::unit_beat_t  q_data,
  input  logic                  q_full
);
  import u2ue_pkg::*;

  front_state_t state_r, state_nxt;

  logic [7:0] lead_r;
  logic [1:0] count_r;
  logic       open_r;
  logic [7:0] pend_r [3];

  logic [7:0] run_r [4];
  logic [2:0] len_r;
  logic [2:0] pos_r;
  logic       done_r;
  logic [15:0] low_r;

  // intake classification
  logic       accept;
  logic       start_run;
  logic       open_seq;
  logic       gather;
  logic [1:0] need;
  logic [2:0] have1;
  logic [7:0] run_nxt [4];
  logic [2:0] len_nxt;

  // run decoder at the current position
  logic [7:0]  dec_c, dec_b1, dec_b2, dec_b3;
  logic [1:0]  dec_f;
  logic        dec_ok;
  logic [20:0] dec_cp;
  logic [20:0] dec_v;
  logic [2:0]  pos_adv;
  logic        is_supp;
  logic        run_end;
  logic        low_end;
  logic [15:0] hi_unit, lo_unit;
  logic        finish;

  always_comb begin
    need      = followers_of(lead_r);
    have1     = {1'b0, count_r} + 3'd1;
    start_run = 1'b0;
    open_seq  = 1'b0;
    gather    = 1'b0;
    len_nxt   = 3'd1;
    run_nxt[0] = in_text_byte;
    for (int k = 0; k < 3; k++) begin
      run_nxt[k+1] = (count_r == k[1:0]) ? in_text_byte : pend_r[k];
    end
    if (open_r) begin
      run_nxt[0] = lead_r;
      len_nxt    = have1 + 3'd1;
      if ((have1 >= {1'b0, need}) || in_end_of_text) start_run = 1'b1;
      else gather = 1'b1;
    end else if ((followers_of(in_text_byte) != 2'd0) && !in_end_of_text) begin
      open_seq = 1'b1;
    end else begin
      start_run = 1'b1;
    end
  end

  always_comb begin
    dec_c   = run_r[pos_r[1:0]];
    dec_b1  = run_r[pos_r[1:0] + 2'd1];
    dec_b2  = run_r[pos_r[1:0] + 2'd2];
    dec_b3  = run_r[pos_r[1:0] + 2'd3];
    dec_f   = followers_of(dec_c);
    dec_ok  = (dec_f != 2'd0) && ((pos_r + {1'b0, dec_f}) < len_r);
    dec_cp  = {13'b0, dec_c};
    pos_adv = pos_r + 3'd1;
    if (dec_ok) begin
      pos_adv = pos_r + {1'b0, dec_f} + 3'd1;
      case (dec_f)
        2'd1:    dec_cp = {10'b0, dec_c[4:0], dec_b1[5:0]};
        2'd2:    dec_cp = {5'b0, dec_c[3:0], dec_b1[5:0], dec_b2[5:0]};
        2'd3:    dec_cp = {dec_c[2:0], dec_b1[5:0], dec_b2[5:0], dec_b3[5:0]};
        default: dec_cp = {13'b0, dec_c};
      endcase
    end
    is_supp = dec_cp[20:16] != 5'd0;
    dec_v   = dec_cp - SUPP_BASE;
    hi_unit = HIGH_SURR_BASE + {5'b0, dec_v[20:10]};
    lo_unit = LOW_SURR_BASE + {6'b0, dec_v[9:0]};
    run_end = pos_adv >= len_r;
    low_end = pos_r >= len_r;
  end

  // outputs
  always_comb begin
    q_push      = 1'b0;
    q_data.unit = dec_cp[15:0];
    q_data.last = 1'b0;
    q_data.done = 1'b0;
    finish      = 1'b0;
    case (state_r)
      FS_DECODE: begin
        q_push      = !q_full;
        q_data.unit = is_supp ? hi_unit : dec_cp[15:0];
        q_data.last = !is_supp && run_end;
        q_data.done = !is_supp && run_end && done_r;
        finish      = q_push && !is_supp && run_end;
      end
      FS_LOW: begin
        q_push      = !q_full;
        q_data.unit = low_r;
        q_data.last = low_end;
        q_data.done = low_end && done_r;
        finish      = q_push && low_end;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
    in_ready = (state_r == FS_IDLE) || finish;
  end

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FS_IDLE: begin
        if (accept && start_run) state_nxt = FS_DECODE;
      end
      FS_DECODE: begin
        if (q_push) begin
          if (is_supp) state_nxt = FS_LOW;
          else if (run_end) state_nxt = (accept && start_run) ? FS_DECODE : FS_IDLE;
        end
      end
      FS_LOW: begin
        if (q_push) begin
          if (low_end) state_nxt = (accept && start_run) ? FS_DECODE : FS_IDLE;
          else state_nxt = FS_DECODE;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      lead_r  <= 8'd0;
      count_r <= 2'd0;
      open_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (open_seq) begin
          lead_r  <= in_text_byte;
          count_r <= 2'd0;
          open_r  <= 1'b1;
        end else if (gather && !in_end_of_text) begin
          count_r <= have1[1:0];
        end else begin
          lead_r  <= 8'd0;
          count_r <= 2'd0;
          open_r  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && gather) pend_r[count_r] <= in_text_byte;
    // a new run only starts while idle or on the last unit of the old one, so no low half is pending
    if (accept && start_run) begin
      for (int k = 0; k < 4; k++) run_r[k] <= run_nxt[k];
      len_r  <= len_nxt;
      pos_r  <= 3'd0;
      done_r <= in_end_of_text;
    end else if (state_r == FS_DECODE && q_push) begin
      pos_r <= pos_adv;
      low_r <= lo_unit;
    end
  end

endmodule

// File: hw/rtl/u2ue_fifo.sv
// small unit queue between front and back
module u2ue_fifo #(
  parameter int DEPTH = u2ue_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u2ue_pkg::unit_beat_t  push_data,
  output logic                  full,
  input  logic                  pop,
  output u2ue_pkg::unit_beat_t  head,
  output logic                  head_valid
);
  import u2ue_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  unit_beat_t    mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full       = count_r == CW'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// File: hw/rtl/u2ue_back.sv
// back end: expands utf-16 units into plain or escaped ascii characters
module u2ue_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  u2ue_pkg::unit_beat_t  q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_char,
  output logic                  out_last_of_run,
  output logic                  out_text_done
);
  import u2ue_pkg::*;

  localparam logic [2:0] POS_SLASH = 3'd0;
  localparam logic [2:0] POS_U     = 3'd1;
  localparam logic [2:0] POS_HEX3  = 3'd2;
  localparam logic [2:0] POS_HEX2  = 3'd3;
  localparam logic [2:0] POS_HEX1  = 3'd4;
  localparam logic [2:0] POS_FINAL = 3'(ESC_LEN - 1);

  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_last_r;
  logic       out_done_r;

  logic       esc;
  logic       final_char;
  logic       load;
  logic [7:0] ch;

  always_comb begin
    esc        = needs_escape(q_data.unit);
    final_char = !esc || (idx_r == POS_FINAL);
    ch         = q_data.unit[7:0];
    if (esc) begin
      case (idx_r)
        POS_SLASH: ch = CHAR_BACKSLASH;
        POS_U:     ch = CHAR_LOWER_U;
        POS_HEX3:  ch = hex_char(q_data.unit[15:12]);
        POS_HEX2:  ch = hex_char(q_data.unit[11:8]);
        POS_HEX1:  ch = hex_char(q_data.unit[7:4]);
        default:   ch = hex_char(q_data.unit[3:0]);
      endcase
    end
  end

  assign load  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = load && final_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= POS_SLASH;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= final_char ? POS_SLASH : idx_r + 3'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char_r <= ch;
      out_last_r <= final_char && q_data.last;
      out_done_r <= final_char && q_data.done;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_last_of_run = out_last_r;
  assign out_text_done   = out_done_r;

endmodule

// File: hw/rtl/utf8_to_unicode_escape_core.sv
// top level of the utf-8 to unicode escape core: front end, unit queue and back end
//
// converts a utf-8 byte stream into escaped ascii text, one byte per input beat and one
// character per output beat. the front end takes bytes while idle: a lead byte or a
// follower opens or extends a sequence with no output; a finished run is decoded into
// utf-16 units, two for a surrogate pair, pushed while the queue is not full, and the
// next byte is taken in the cycle the last unit of a run enters the queue, so plain ascii
// flows at one byte per cycle. the back end turns each queued unit into one character, or
// into six (backslash, u, four lower-case hex digits) for units below 0x20 or above 0x7e,
// at one character per cycle while out_ready is high; its single output register sets the
// sustained output rate. an unfinished sequence at end of text is flushed as its lead byte
// followed by a fresh decode of the gathered bytes, at most 18 characters.
`include "utf8_to_unicode_escape_core_assert.svh"

module utf8_to_unicode_escape_core #(
  parameter int QUEUE_DEPTH = u2ue_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_text_done
);
  import u2ue_pkg::*;

  // front to queue
  logic       q_push;
  unit_beat_t q_push_data;
  logic       q_full;
  // queue to back
  logic       q_pop;
  unit_beat_t q_head;
  logic       q_valid;

  // byte intake, sequence gathering and run decode
  u2ue_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .q_push         (q_push),
    .q_data         (q_push_data),
    .q_full         (q_full)
  );

  // decouples the decoder from the character output
  u2ue_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  // unit expansion into output beats
  u2ue_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last_of_run (out_last_of_run),
    .out_text_done   (out_text_done)
  );

  // the front end never pushes into a full queue
  `U2UE_ASSERT(a_no_push_when_full, q_push |-> !q_full, "unit pushed into full queue")
  // the back end only pops a unit that is there
  `U2UE_ASSERT(a_no_pop_when_empty, q_pop |-> q_valid, "unit popped from empty queue")
  // end of text always closes the run of its byte
  `U2UE_ASSERT(a_done_marks_last, out_valid && out_text_done |-> out_last_of_run,
    "text end flagged on a character that does not end its run")
  // an output beat that is not taken stays put with its payload
  `U2UE_ASSERT_NEXT(a_out_held, out_valid && !out_ready,
    out_valid && $stable(out_char) && $stable(out_last_of_run) && $stable(out_text_done),
    "output beat changed before it was taken")

endmodule
